// File: rtl/core/fpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_pkg
// Shared types, constants and fixed-point helpers of the fractal noise unit.
// ----------------------------------------------------------------------------
package fpn_pkg;

  localparam int VAL_W = 24;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam logic [31:0] HASH_C1 = 32'h85ebca6b;
  localparam logic [31:0] HASH_C2 = 32'hc2b2ae35;
  localparam int ONE_Q16 = 65536;

  localparam logic [1:0] REG_SEED  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_PERS  = 2'd2;

  // Q16 product; taking the upper bits of the signed product rounds toward minus infinity.
  function automatic val_t mulq(input val_t a, input val_t b);
    logic signed [2*VAL_W-1:0] prod;
    prod = a * b;
    return prod[VAL_W+15:16];
  endfunction

endpackage

// File: rtl/core/fpn_octave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_octave
// One octave lane: seven register stages of hashing, fade and weighting.
// ----------------------------------------------------------------------------
module fpn_octave import fpn_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int OCTAVE = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] position,
  input  logic [31:0]        seed,
  input  logic [16:0]        amp,
  input  logic               active,
  output val_t               weighted
);

  logic [63:0] scaled;
  logic [31:0] cell_idx, cell_b, mix_a, mix_b;
  logic [15:0] t_in;

  assign scaled   = {{32{position[31]}}, position} << OCTAVE;
  assign cell_idx = scaled[FRAC_BITS +: 32];
  assign cell_b   = cell_idx + 32'd1;
  assign mix_a  = (cell_idx ^ (seed + 32'(OCTAVE))) ^
                  ((cell_idx ^ (seed + 32'(OCTAVE))) >> 16);
  assign mix_b  = (cell_b ^ (seed + 32'(OCTAVE))) ^ ((cell_b ^ (seed + 32'(OCTAVE))) >> 16);

  generate
    if (FRAC_BITS >= 16) begin : g_down
      assign t_in = 16'(scaled[FRAC_BITS-1:0] >> (FRAC_BITS - 16));
    end else begin : g_up
      assign t_in = 16'({scaled[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}});
    end
  endgenerate

  logic [31:0] x0, x1, ha0, ha1, hb0, hb1;
  logic [31:0] hb0_mix, hb1_mix;
  logic [63:0] pa0, pa1, pb0, pb1;
  val_t t1, t2, t3, t4;
  val_t sq2, pq2, cu3, p3, g0, g1, fade4, fade5, d0, d1, d0_6, m6;

  assign pa0 = x0 * HASH_C1;
  assign pa1 = x1 * HASH_C1;
  assign hb0_mix = ha0 ^ (ha0 >> 13);
  assign hb1_mix = ha1 ^ (ha1 >> 13);
  assign pb0 = hb0_mix * HASH_C2;
  assign pb1 = hb1_mix * HASH_C2;

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: cell decode and first mix step.
      x0 <= mix_a;
      x1 <= mix_b;
      t1 <= val_t'(t_in);
      // Stage 2: first hash multiply, t squared and the inner fade term.
      ha0 <= pa0[31:0];
      ha1 <= pa1[31:0];
      sq2 <= mulq(t1, t1);
      pq2 <= mulq(t1, val_t'(6 * t1 - val_t'(15 * ONE_Q16)));
      t2  <= t1;
      // Stage 3: second hash multiply, t cubed.
      hb0 <= pb0[31:0];
      hb1 <= pb1[31:0];
      cu3 <= mulq(sq2, t2);
      p3  <= pq2 + val_t'(10 * ONE_Q16);
      t3  <= t2;
      // Stage 4: gradients and fade.
      g0    <= val_t'({1'b0, (hb0 ^ (hb0 >> 16)) >> 15}) - val_t'(ONE_Q16);
      g1    <= val_t'({1'b0, (hb1 ^ (hb1 >> 16)) >> 15}) - val_t'(ONE_Q16);
      fade4 <= mulq(cu3, p3);
      t4    <= t3;
      // Stage 5: corner contributions.
      d0    <= mulq(g0, t4);
      d1    <= mulq(g1, t4 - val_t'(ONE_Q16));
      fade5 <= fade4;
      // Stage 6: blend.
      m6   <= mulq(fade5, d1 - d0);
      d0_6 <= d0;
      // Stage 7: amplitude weight, zero for octaves past the count.
      weighted <= active ? mulq(d0_6 + m6, val_t'({1'b0, amp})) : '0;
    end
  end

endmodule

// File: rtl/core/fpn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module fpn_div import fpn_pkg::*; #(
  parameter int SUM_W = 28,
  parameter int DEN_W = 21
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    sum_valid,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [DEN_W-1:0]        den,
  output logic                    out_valid,
  output logic signed [17:0]      quotient
);

  localparam int QB = 17;
  localparam int W = ((SUM_W + 16) > (DEN_W + QB) ? (SUM_W + 16) : (DEN_W + QB)) + 1;

  logic             rv   [0:QB];
  logic             rneg [0:QB];
  logic             rovf [0:QB];
  logic [W-1:0]     rem  [0:QB];
  logic [QB-1:0]    q    [0:QB];
  logic [SUM_W-1:0] mag;
  logic [QB-1:0]    qs;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rneg[0] <= sum[SUM_W-1];
      rem[0]  <= W'(mag) << 16;
      rovf[0] <= (W'(mag) << 16) >= (W'(den) << QB);
      q[0]    <= '0;
    end
  end

  generate
    for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int B = QB - 1 - k;
      logic [W:0] diff;
      assign diff = {1'b0, rem[k]} - {1'b0, W'(den) << B};

      always_ff @(posedge clk) begin
        if (rst) begin
          rv[k+1] <= 1'b0;
        end else if (en) begin
          rv[k+1] <= rv[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]  <= diff[W] ? rem[k] : diff[W-1:0];
          q[k+1]    <= diff[W] ? q[k] : (q[k] | (QB'(1) << B));
          rneg[k+1] <= rneg[k];
          rovf[k+1] <= rovf[k];
        end
      end
    end
  endgenerate

  assign qs = (rovf[QB] || q[QB] > QB'(ONE_Q16)) ? QB'(ONE_Q16) : q[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= rneg[QB] ? -18'(qs) : 18'(qs);
    end
  end

endmodule

// File: rtl/core/fractal_perlin_noise_1d_unit.sv
`timescale 1ns / 1ps
// Pipeline: 7 lane stages, 1 sum register, 1 divider setup register, 17 quotient
// stages and 1 output register. Throughput: one item per cycle while in_stall is low;
// one global enable holds the pipe when out_valid and out_stall are both high.
// Reset and every register write rebuild the octave amplitude table, one octave
// per cycle, with in_stall high meanwhile.
// ----------------------------------------------------------------------------
// fractal_perlin_noise_1d_unit
// One-dimensional fractal Perlin noise, all octaves in parallel lanes.
// ----------------------------------------------------------------------------
module fractal_perlin_noise_1d_unit import fpn_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] noise_value
);

  localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int GROW  = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = VAL_W + GROW;
  localparam int AMPS_W = 17 + GROW;
  localparam int LANE_LAT = 7;

  logic [31:0]       noise_seed;
  logic [3:0]        octave_count;
  logic [16:0]       persistence;
  logic [4:0]        cnt_eff;
  logic [16:0]       pers_eff;

  logic              busy;
  logic [IDX_W-1:0]  widx;
  logic [16:0]       cur;
  logic [AMPS_W-1:0] acc, acc_next, amp_sum;
  logic [33:0]       cur_prod;
  logic [16:0]       amp [0:MAX_OCTAVES-1];

  logic              en;
  logic              vld [1:LANE_LAT];
  val_t              weighted [0:MAX_OCTAVES-1];
  logic signed [SUM_W-1:0] sum_total, sum_reg;
  logic              sum_vld;

  assign cnt_eff = (octave_count == 4'd0) ? 5'd1 :
                   ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) :
                   {1'b0, octave_count};
  assign pers_eff = (persistence > 17'(ONE_Q16)) ? 17'(ONE_Q16) : persistence;

  // Amplitude table walk: amp[k] = persistence^k, and the sum over active octaves.
  assign cur_prod = cur * pers_eff;
  assign acc_next = (5'(widx) < cnt_eff) ? acc + AMPS_W'(cur) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed   <= '0;
      octave_count <= 4'd4;
      persistence  <= 17'd32768;
      busy         <= 1'b1;
      widx         <= '0;
      cur          <= 17'(ONE_Q16);
      acc          <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEED:  noise_seed   <= cfg_data;
        REG_COUNT: octave_count <= cfg_data[3:0];
        REG_PERS:  persistence  <= cfg_data[16:0];
        default: ;
      endcase
      busy <= 1'b1;
      widx <= '0;
      cur  <= 17'(ONE_Q16);
      acc  <= '0;
    end else if (busy) begin
      acc <= acc_next;
      cur <= cur_prod[32:16];
      if (widx == IDX_W'(MAX_OCTAVES - 1)) begin
        busy <= 1'b0;
      end else begin
        widx <= widx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !cfg_write) begin
      amp[widx] <= cur;
      if (widx == IDX_W'(MAX_OCTAVES - 1)) begin
        amp_sum <= acc_next;
      end
    end
  end

  assign en = !out_valid || !out_stall;
  assign in_stall = busy || !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LANE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
      sum_vld <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid && !busy;
      for (int k = 2; k <= LANE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      sum_vld <= vld[LANE_LAT];
    end
  end

  generate
    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      fpn_octave #(
        .FRAC_BITS(FRAC_BITS),
        .OCTAVE(i)
      ) u_octave (
        .clk(clk),
        .en(en),
        .position(position),
        .seed(noise_seed),
        .amp(amp[i]),
        .active(5'(i) < cnt_eff),
        .weighted(weighted[i])
      );
    end
  endgenerate

  always_comb begin
    sum_total = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      sum_total = sum_total + SUM_W'(weighted[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_reg <= sum_total;
    end
  end

  fpn_div #(
    .SUM_W(SUM_W),
    .DEN_W(AMPS_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .sum_valid(sum_vld),
    .sum(sum_reg),
    .den(amp_sum),
    .out_valid(out_valid),
    .quotient(noise_value)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("item accepted while amplitude table rebuilds");

  a_write_starts_walk: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> busy)
    else $error("register write did not restart the amplitude walk");

  a_amp_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (amp_sum != '0))
    else $error("amplitude sum is zero");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (noise_value <= 18'sd65536 && noise_value >= -18'sd65536))
    else $error("noise value out of range");

endmodule

// File: bench/fpn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_checker
// Watches the configuration port and both item channels of the noise unit.
// For each accepted position it computes the expected noise value and
// compares every delivered result, in order, against it.
// ----------------------------------------------------------------------------
module fpn_checker import fpn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [17:0] noise_value,
  output int                 failures,
  output int                 pending,
  output int                 results_seen
);

  localparam int OCT_LIMIT = 8;

  logic [31:0] seed_q;
  logic [3:0]  count_q;
  logic [16:0] pers_q;

  logic signed [17:0] noise_expected[$];

  function automatic longint mul16(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint hash_gradient(logic [31:0] corner, logic [31:0] seed);
    logic [31:0] h;
    h = corner ^ seed;
    h = h ^ (h >> 16);
    h = h * HASH_C1;
    h = h ^ (h >> 13);
    h = h * HASH_C2;
    h = h ^ (h >> 16);
    return longint'(h >> 15) - ONE_Q16;
  endfunction

  function automatic longint octave_value(logic [63:0] scaled, logic [31:0] seed);
    logic [31:0] cell_idx;
    longint t, g0, g1, d0, d1, t2, t3, p, fd;
    cell_idx = scaled[47:16];
    t = longint'(scaled[15:0]);
    g0 = hash_gradient(cell_idx, seed);
    g1 = hash_gradient(cell_idx + 32'd1, seed);
    d0 = mul16(g0, t);
    d1 = mul16(g1, t - ONE_Q16);
    t2 = mul16(t, t);
    t3 = mul16(t2, t);
    p = mul16(t, 6 * t - 15 * ONE_Q16) + 10 * ONE_Q16;
    fd = mul16(t3, p);
    return d0 + mul16(fd, d1 - d0);
  endfunction

  function automatic logic signed [17:0] fbm_noise(logic signed [31:0] pos);
    logic [63:0] pos64;
    int count;
    longint pers, amp, total, amp_total, res;
    pos64 = 64'(longint'(pos));
    count = count_q;
    pers = pers_q;
    amp = ONE_Q16;
    total = 0;
    amp_total = 0;
    if (count < 1) count = 1;
    if (count > OCT_LIMIT) count = OCT_LIMIT;
    if (pers > ONE_Q16) pers = ONE_Q16;
    for (int i = 0; i < count; i++) begin
      total += mul16(octave_value(pos64 << i, seed_q + 32'(i)), amp);
      amp_total += amp;
      amp = mul16(amp, pers);
    end
    res = (total * ONE_Q16) / amp_total;
    if (res > ONE_Q16) res = ONE_Q16;
    if (res < -ONE_Q16) res = -ONE_Q16;
    return 18'(res);
  endfunction

  always @(posedge clk) begin
    logic signed [17:0] want;
    if (rst) begin
      seed_q <= 32'd0;
      count_q <= 4'd4;
      pers_q <= 17'd32768;
      noise_expected.delete();
      failures <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SEED:  seed_q <= cfg_data;
          REG_COUNT: count_q <= cfg_data[3:0];
          REG_PERS:  pers_q <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        noise_expected.push_back(fbm_noise(position));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected noise_value %0d", $time, noise_value);
          failures <= failures + 1;
        end else begin
          want = noise_expected.pop_front();
          if (want !== noise_value) begin
            $display("%0t: noise_value expected %0d actual %0d", $time, want, noise_value);
            failures <= failures + 1;
          end
        end
      end
      pending <= noise_expected.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives positions and register settings into the fractal noise unit with
// random gaps and back-pressure; the checker beside it judges the results.
// ----------------------------------------------------------------------------
module tb_top import fpn_pkg::*;;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] position;
  logic               out_valid;
  logic               out_stall;
  logic signed [17:0] noise_value;

  int failures, pending, results_seen;
  int send_idle_pct, recv_idle_pct;
  int items_sent;
  bit hold_req;
  bit late;

  fractal_perlin_noise_1d_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .position(position),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  fpn_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .position(position),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value),
    .failures(failures), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    int hold_left;
    bit hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 200;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("fractal_perlin_noise_1d_unit test failed");
    $finish;
  end

  task automatic send_item(logic signed [31:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      position = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    position = pos;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    // Let the pipe drain and the amplitude table settle.
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data = $urandom;
  endtask

  task automatic set_noise(logic [31:0] seed, logic [31:0] count, logic [31:0] pers);
    wait_idle();
    write_reg(REG_SEED, seed);
    write_reg(REG_COUNT, count);
    write_reg(REG_PERS, pers);
  endtask

  function automatic logic signed [31:0] rand_position();
    case ($urandom_range(5))
      0: return $signed($urandom_range(65535)) - 32768;
      1: return {16'h7fff, 16'($urandom)};
      2: return {16'h8000, 16'($urandom)};
      3: return {16'($urandom_range(7)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 30 == 0) send_idle_pct = (k / 30) % 3 == 0 ? 28 : ((k / 30) % 3 == 1 ? 57 : 0);
      if (k % 30 == 0) recv_idle_pct = (k / 30) % 3 == 0 ? 57 : ((k / 30) % 3 == 1 ? 28 : 0);
      send_item(rand_position());
    end
  endtask

  initial begin
    logic signed [31:0] directed[] = '{32'sd0, 32'sd1, 32'sh0000ffff, 32'sh00010000,
      -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fff0000, 32'sh8000ffff,
      32'sh00008000, 32'shffff8000, 32'sh00018000, 32'sh55555555, 32'shaaaaaaaa};
    int waited;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SEED;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    position = 32'sd0;
    hold_req = 1'b0;
    items_sent = 0;
    send_idle_pct = 28;
    recv_idle_pct = 57;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Reset settings first, then the extremes of every register.
    foreach (directed[j]) send_item(directed[j]);
    set_noise(32'hffffffff, 1, 0);
    foreach (directed[j]) send_item(directed[j]);
    set_noise(32'h0, 8, 65536);
    foreach (directed[j]) send_item(directed[j]);
    // Zero count acts as one octave; large count and persistence saturate.
    set_noise(32'h12345678, 0, 32'h0001ffff);
    for (int j = 0; j < 6; j++) send_item(directed[j]);
    set_noise(32'hedcba987, 15, 32'hfffe0001);
    for (int j = 0; j < 6; j++) send_item(directed[j]);
    // An unused register index must change nothing.
    wait_idle();
    write_reg(REG_UNUSED, 32'hffffffff);
    for (int j = 0; j < 4; j++) send_item(directed[j]);

    for (int ph = 0; ph < 6; ph++) begin
      set_noise($urandom, $urandom_range(ph < 3 ? 4 : 8, 1), $urandom_range(65536));
      if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (60) send_item(rand_position());
      end
      run_random(75);
    end

    while (pending != 0) @(negedge clk);
    waited = 0;
    late = 1'b0;
    while (waited < 60) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) late = 1'b1;
    $display("Sent %0d positions over eleven register settings, with gaps, stalls and",
             items_sent);
    $display("one long output hold-off; %0d results checked.", results_seen);
    if (failures == 0 && !late) begin
      $display("fractal_perlin_noise_1d_unit test passed");
    end else begin
      $display("fractal_perlin_noise_1d_unit test failed");
    end
    $finish;
  end

endmodule

// File: fractal_perlin_noise_1d_unit.f
rtl/core/fpn_pkg.sv
rtl/core/fpn_octave.sv
rtl/core/fpn_div.sv
rtl/core/fractal_perlin_noise_1d_unit.sv
bench/fpn_checker.sv
bench/tb_top.sv
